// File: rtl/glp_pkg.sv
package glp_pkg;

   localparam int MAX_CHIPS_DEF    = 4;
   localparam int COLOR_PLANES_DEF = 3;

   localparam int CHAN_PER_CHIP  = 16;
   localparam int PAIRS_PER_CHIP = 8;
   localparam int BYTES_PER_CHIP = 24;

   localparam int WORD_W   = 12;
   localparam int BITS_MIN = 8;
   localparam int BITS_MAX = 12;
   localparam int GAMMA_TABLES = BITS_MAX - BITS_MIN + 1;

   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   localparam logic [1:0] CSR_CHIP_COUNT = 2'd0;
   localparam logic [1:0] CSR_PWM_BITS   = 2'd1;
   localparam logic [1:0] CSR_BREADBOARD = 2'd2;

   localparam logic [1:0] BYTE_HI  = 2'd0;
   localparam logic [1:0] BYTE_MID = 2'd1;

   typedef struct packed {
      logic       wr_en;
      logic       wr_odd;
      logic       rd_en;
      logic       clr;
      logic       err;
      logic [1:0] byte_sel;
   } glp_op_type;

   typedef logic [GAMMA_TABLES-1:0][255:0][WORD_W-1:0] gamma_rom_type;

   // round(M * (p/255)^2.5): largest v with (2v-1)^2 * 255^5 <= 4 * M^2 * p^5
   function automatic gamma_rom_type build_gamma_rom();
      gamma_rom_type rom;
      logic [95:0]   full;
      logic [95:0]   p5;
      logic [95:0]   lo;
      logic [95:0]   hi;
      logic [95:0]   mid;
      logic [95:0]   t;
      logic [95:0]   pw;
      rom = '0;
      pw  = 96'd1078203909375;
      for (int b = 0; b < GAMMA_TABLES; b++) begin
         full = (96'd1 << (b + BITS_MIN)) - 96'd1;
         for (int p = 0; p < 256; p++) begin
            p5 = 96'(p) * 96'(p) * 96'(p) * 96'(p) * 96'(p);
            lo = '0;
            hi = full;
            for (int it = 0; it <= BITS_MAX; it++) begin
               if (lo < hi) begin
                  mid = (lo + hi + 96'd1) >> 1;
                  t   = (mid << 1) - 96'd1;
                  if (t * t * pw <= 96'd4 * full * full * p5) begin
                     lo = mid;
                  end else begin
                     hi = mid - 96'd1;
                  end
               end
            end
            rom[b][p] = lo[WORD_W-1:0];
         end
      end
      return rom;
   endfunction

   localparam gamma_rom_type GAMMA_ROM = build_gamma_rom();

endpackage

// File: rtl/glp_ram.sv
module glp_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 96
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/glp_decode.sv
module glp_decode #(
   parameter int MAX_CHIPS    = glp_pkg::MAX_CHIPS_DEF,
   parameter int COLOR_PLANES = glp_pkg::COLOR_PLANES_DEF
) (
   input  logic [1:0]                                      cmd,
   input  logic [5:0]                                      led_row,
   input  logic [1:0]                                      color,
   input  logic [7:0]                                      pixel_value,
   input  logic [6:0]                                      byte_index,
   input  logic [2:0]                                      chip_count,
   input  logic [3:0]                                      pwm_bits,
   input  logic                                            breadboard_mode,
   output glp_pkg::glp_op_type                             op,
   output logic [$clog2(8*MAX_CHIPS*COLOR_PLANES)-1:0]     wr_addr,
   output logic [glp_pkg::WORD_W-1:0]                      wr_data,
   output logic [$clog2(8*MAX_CHIPS*COLOR_PLANES)-1:0]     rd_addr
);

   import glp_pkg::*;

   localparam int ADDR_W = $clog2(PAIRS_PER_CHIP * MAX_CHIPS * COLOR_PLANES);
   localparam int PAIRS_PER_PLANE = PAIRS_PER_CHIP * MAX_CHIPS;
   localparam int CC_W = ($clog2(MAX_CHIPS + 1) > 3) ? $clog2(MAX_CHIPS + 1) : 3;
   localparam int CH_W = CC_W + 4;
   localparam int BY_W = CC_W + 5;
   localparam logic [CC_W-1:0] MAX_CC = CC_W'(MAX_CHIPS);
   localparam int RECIP3 = 171;

   logic [CC_W-1:0]   cc;
   logic [CC_W-1:0]   eff;
   logic [CH_W-1:0]   chans;
   logic [CH_W-1:0]   half;
   logic [CH_W-1:0]   rowx;
   logic [CH_W-1:0]   out_no;
   logic [CH_W-1:0]   ch;
   logic [BY_W-1:0]   bytes_lim;
   logic              row_bad;
   logic              color_bad;
   logic              byte_bad;
   logic [2:0]        gidx;
   logic [14:0]       quot_prod;
   logic [5:0]        pair_k;
   logic [6:0]        rem;
   logic [ADDR_W-1:0] plane_base;

   always_comb begin
      cc = CC_W'(chip_count);
      if (cc == '0) begin
         eff = CC_W'(1);
      end else if (cc > MAX_CC) begin
         eff = MAX_CC;
      end else begin
         eff = cc;
      end
      chans = {eff, 4'b0000};
      half  = CH_W'({eff, 3'b000});
      rowx  = CH_W'(led_row);

      if (breadboard_mode) begin
         out_no = (rowx < half) ? (rowx << 1) : (((rowx - half) << 1) | CH_W'(1));
      end else begin
         out_no = rowx;
      end
      ch = chans - CH_W'(1) - out_no;

      if (pwm_bits < 4'(BITS_MIN)) begin
         gidx = 3'd0;
      end else if (pwm_bits > 4'(BITS_MAX)) begin
         gidx = 3'(GAMMA_TABLES - 1);
      end else begin
         gidx = 3'(pwm_bits - 4'(BITS_MIN));
      end

      bytes_lim = BY_W'(eff) * BY_W'(BYTES_PER_CHIP);
      row_bad   = rowx >= chans;
      color_bad = 3'(color) >= 3'(COLOR_PLANES);
      byte_bad  = BY_W'(byte_index) >= bytes_lim;

      // divide by 3 via reciprocal, exact for 7-bit indexes
      quot_prod = 15'(byte_index) * 15'(RECIP3);
      pair_k    = quot_prod[14:9];
      rem       = byte_index - 7'(7'(pair_k) * 7'd3);

      plane_base = ADDR_W'(color) * ADDR_W'(PAIRS_PER_PLANE);
      wr_addr    = plane_base + ADDR_W'(ch[CH_W-1:1]);
      rd_addr    = plane_base + ADDR_W'(pair_k);
      wr_data    = GAMMA_ROM[gidx][pixel_value];

      op          = '0;
      op.wr_odd   = ch[0];
      op.byte_sel = rem[1:0];
      unique case (cmd)
         CMD_WRITE: begin
            op.err   = row_bad | color_bad;
            op.wr_en = ~(row_bad | color_bad);
         end
         CMD_READ: begin
            op.err   = byte_bad | color_bad;
            op.rd_en = ~(byte_bad | color_bad);
         end
         CMD_CLEAR: begin
            op.clr = 1'b1;
         end
         default: begin
         end
      endcase
   end

endmodule

// File: rtl/glp_frame_store.sv
module glp_frame_store #(
   parameter int MAX_CHIPS    = glp_pkg::MAX_CHIPS_DEF,
   parameter int COLOR_PLANES = glp_pkg::COLOR_PLANES_DEF
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        accept,
   input  glp_pkg::glp_op_type                         op,
   input  logic [$clog2(8*MAX_CHIPS*COLOR_PLANES)-1:0] wr_addr,
   input  logic [glp_pkg::WORD_W-1:0]                  wr_data,
   input  logic [$clog2(8*MAX_CHIPS*COLOR_PLANES)-1:0] rd_addr,
   output logic [glp_pkg::WORD_W-1:0]                  word0,
   output logic [glp_pkg::WORD_W-1:0]                  word1
);

   import glp_pkg::*;

   localparam int PAIR_DEPTH = PAIRS_PER_CHIP * MAX_CHIPS * COLOR_PLANES;

   logic                  wr_even;
   logic                  wr_odd;
   logic                  rd;
   logic                  clr;
   logic [PAIR_DEPTH-1:0] valid_even_ff;
   logic [PAIR_DEPTH-1:0] valid_even_in;
   logic [PAIR_DEPTH-1:0] valid_odd_ff;
   logic [PAIR_DEPTH-1:0] valid_odd_in;
   logic                  ve_q_ff;
   logic                  vo_q_ff;
   logic [WORD_W-1:0]     q_even;
   logic [WORD_W-1:0]     q_odd;

   assign wr_even = accept & op.wr_en & ~op.wr_odd;
   assign wr_odd  = accept & op.wr_en & op.wr_odd;
   assign rd      = accept & op.rd_en;
   assign clr     = accept & op.clr;

   glp_ram #(
      .WIDTH (WORD_W),
      .DEPTH (PAIR_DEPTH)
   ) u_even (
      .clock   (clock),
      .wr_en   (wr_even),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd),
      .rd_addr (rd_addr),
      .rd_data (q_even)
   );

   glp_ram #(
      .WIDTH (WORD_W),
      .DEPTH (PAIR_DEPTH)
   ) u_odd (
      .clock   (clock),
      .wr_en   (wr_odd),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd),
      .rd_addr (rd_addr),
      .rd_data (q_odd)
   );

   // unwritten words read as zero; clear drops every valid bit at once
   always_comb begin
      valid_even_in = valid_even_ff;
      valid_odd_in  = valid_odd_ff;
      if (clr) begin
         valid_even_in = '0;
         valid_odd_in  = '0;
      end else begin
         if (wr_even) begin
            valid_even_in[wr_addr] = 1'b1;
         end
         if (wr_odd) begin
            valid_odd_in[wr_addr] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_even_ff <= '0;
         valid_odd_ff  <= '0;
      end else begin
         valid_even_ff <= valid_even_in;
         valid_odd_ff  <= valid_odd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd) begin
         ve_q_ff <= valid_even_ff[rd_addr];
         vo_q_ff <= valid_odd_ff[rd_addr];
      end
   end

   assign word0 = ve_q_ff ? q_even : '0;
   assign word1 = vo_q_ff ? q_odd  : '0;

endmodule

// File: rtl/led_grayscale_packer_core.sv
// Column-frame packer for a chain of 16-channel, 12-bit grayscale LED drivers.
// A write transaction gamma-corrects an 8-bit pixel through a 5 x 256 entry
// ROM (8 to 12 bit scale), maps the row to a driver output (breadboard order
// optional), reverses the chain order and stores the word for its colour
// plane. A read transaction returns one byte of the packed plane, with each
// channel pair packed into three bytes; clear zeroes the whole frame at once.
// One transaction is accepted every cycle unless the response side stalls; its
// response passes the registered read of the frame RAMs (even and odd channel
// banks), then the response register. Configuration is to be written by the
// user via csr_we/csr_index/csr_wdata while idle; the block does not enforce it.
module led_grayscale_packer_core #(
   parameter int MAX_CHIPS    = glp_pkg::MAX_CHIPS_DEF,
   parameter int COLOR_PLANES = glp_pkg::COLOR_PLANES_DEF
) (
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_cmd,
   input  logic [5:0] req_led_row,
   input  logic [1:0] req_color,
   input  logic [7:0] req_pixel_value,
   input  logic [6:0] req_byte_index,

   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_read_data,
   output logic       rsp_row_error,

   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [3:0] csr_wdata
);

   import glp_pkg::*;

   localparam int ADDR_W = $clog2(PAIRS_PER_CHIP * MAX_CHIPS * COLOR_PLANES);

   logic [2:0]        chip_count_ff;
   logic [3:0]        pwm_bits_ff;
   logic              breadboard_ff;

   logic              accept;
   logic              adv;
   glp_op_type        op;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic [WORD_W-1:0] wr_data;
   logic [WORD_W-1:0] word0;
   logic [WORD_W-1:0] word1;

   logic              s1_valid_ff;
   logic              s1_valid_in;
   glp_op_type        s1_op_ff;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [7:0]        rsp_read_data_ff;
   logic [7:0]        rsp_read_data_in;
   logic              rsp_row_error_ff;
   logic [7:0]        byte_sel_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         chip_count_ff <= 3'd1;
         pwm_bits_ff   <= 4'd12;
         breadboard_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CHIP_COUNT: chip_count_ff <= csr_wdata[2:0];
            CSR_PWM_BITS:   pwm_bits_ff   <= csr_wdata;
            CSR_BREADBOARD: breadboard_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   assign adv       = ~rsp_valid_ff | rsp_ready;
   assign req_ready = ~s1_valid_ff | adv;
   assign accept    = req_valid & req_ready;

   glp_decode #(
      .MAX_CHIPS    (MAX_CHIPS),
      .COLOR_PLANES (COLOR_PLANES)
   ) u_decode (
      .cmd             (req_cmd),
      .led_row         (req_led_row),
      .color           (req_color),
      .pixel_value     (req_pixel_value),
      .byte_index      (req_byte_index),
      .chip_count      (chip_count_ff),
      .pwm_bits        (pwm_bits_ff),
      .breadboard_mode (breadboard_ff),
      .op              (op),
      .wr_addr         (wr_addr),
      .wr_data         (wr_data),
      .rd_addr         (rd_addr)
   );

   glp_frame_store #(
      .MAX_CHIPS    (MAX_CHIPS),
      .COLOR_PLANES (COLOR_PLANES)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .op      (op),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .word0   (word0),
      .word1   (word1)
   );

   always_comb begin
      case (s1_op_ff.byte_sel)
         BYTE_HI:  byte_sel_data = word0[11:4];
         BYTE_MID: byte_sel_data = {word0[3:0], word1[11:8]};
         default:  byte_sel_data = word1[7:0];
      endcase
      rsp_read_data_in = s1_op_ff.rd_en ? byte_sel_data : 8'd0;
      rsp_valid_in     = adv ? s1_valid_ff : rsp_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff <= op;
      end
      if (adv && s1_valid_ff) begin
         rsp_read_data_ff <= rsp_read_data_in;
         rsp_row_error_ff <= s1_op_ff.err;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_read_data_ff;
   assign rsp_row_error = rsp_row_error_ff;

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !adv |=> s1_valid_ff)
      else $error("pipeline stage lost a held transaction");

   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> s1_valid_ff && rsp_valid_ff)
      else $error("ready low with room in the pipeline");

   a_err_blocks: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_op_ff.err |-> !s1_op_ff.wr_en && !s1_op_ff.rd_en)
      else $error("refused transaction touched the frame");

   a_err_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_row_error |-> rsp_read_data == 8'd0)
      else $error("refused read returned data");

endmodule

// File: bench/tb_led_grayscale_packer_core.sv
module tb_led_grayscale_packer_core;
   timeunit 1ns;
   timeprecision 1ps;

   import glp_pkg::*;

   localparam logic [1:0] CMD_UNUSED  = 2'd3;
   localparam logic [1:0] CSR_SPARE   = 2'd3;
   localparam logic [1:0] PLANE_RED   = 2'd0;
   localparam logic [1:0] PLANE_GREEN = 2'd1;
   localparam logic [1:0] PLANE_BLUE  = 2'd2;
   localparam logic [1:0] PLANE_NONE  = 2'd3;

   localparam logic [127:0] POW_255_5  = 128'd1078203909375;
   localparam int           IDLE_LIMIT = 2000;

   typedef struct packed {
      logic [7:0] data;
      logic       err;
   } packed_rsp_type;

   logic       clock           = 1'b0;
   logic       reset           = 1'b1;
   logic       req_valid       = 1'b0;
   logic       req_ready;
   logic [1:0] req_cmd         = '0;
   logic [5:0] req_led_row     = '0;
   logic [1:0] req_color       = '0;
   logic [7:0] req_pixel_value = '0;
   logic [6:0] req_byte_index  = '0;
   logic       rsp_valid;
   logic       rsp_ready       = 1'b1;
   logic [7:0] rsp_read_data;
   logic       rsp_row_error;
   logic       csr_we          = 1'b0;
   logic [1:0] csr_index       = '0;
   logic [3:0] csr_wdata       = '0;

   packed_rsp_type due_rsp_q[$];
   logic [11:0] frame_word [0:2][0:63];
   logic [2:0]  cfg_chips = 3'd1;
   logic [3:0]  cfg_bits  = 4'd12;
   logic        cfg_bb    = 1'b0;

   int fail_count    = 0;
   int idle_cycles   = 0;
   int rx_hold_cycles = 0;
   bit tx_burst      = 1'b0;
   bit rx_burst      = 1'b0;

   led_grayscale_packer_core u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_led_row     (req_led_row),
      .req_color       (req_color),
      .req_pixel_value (req_pixel_value),
      .req_byte_index  (req_byte_index),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_read_data   (rsp_read_data),
      .rsp_row_error   (rsp_row_error),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int live_chips();
      if (cfg_chips == 3'd0) begin
         return 1;
      end
      if (cfg_chips > 3'd4) begin
         return 4;
      end
      return int'(cfg_chips);
   endfunction

   // largest v <= full scale with (2v-1)^2 * 255^5 <= 4 * M^2 * p^5, built bit by bit
   function automatic logic [11:0] gamma_word(input logic [7:0] pix);
      logic [127:0] full;
      logic [127:0] p;
      logic [127:0] rhs;
      logic [127:0] t;
      logic [11:0]  v;
      logic [11:0]  cand;
      int           nbits;
      nbits = (cfg_bits < 4'd8) ? 8 : ((cfg_bits > 4'd12) ? 12 : int'(cfg_bits));
      full  = (128'd1 << nbits) - 128'd1;
      p     = 128'(pix);
      rhs   = 128'd4 * full * full * p * p * p * p * p;
      v     = '0;
      for (int b = 11; b >= 0; b--) begin
         cand = v | (12'd1 << b);
         t    = 128'(cand) * 128'd2 - 128'd1;
         if (128'(cand) <= full && t * t * POW_255_5 <= rhs) begin
            v = cand;
         end
      end
      return v;
   endfunction

   task automatic clear_frame();
      foreach (frame_word[c, i]) begin
         frame_word[c][i] = '0;
      end
   endtask

   task automatic update_frame(input logic [1:0] cmd, input logic [5:0] row,
                               input logic [1:0] color, input logic [7:0] pix,
                               input logic [6:0] bidx);
      int          chans;
      int          row_i;
      int          outn;
      int          k;
      logic [11:0] w0;
      logic [11:0] w1;
      packed_rsp_type r;
      chans = 16 * live_chips();
      row_i = int'(row);
      r     = '0;
      case (cmd)
         CMD_WRITE: begin
            if (row_i >= chans || color > PLANE_BLUE) begin
               r.err = 1'b1;
            end else begin
               if (cfg_bb) begin
                  outn = (row_i < chans / 2) ? 2 * row_i : 2 * (row_i - chans / 2) + 1;
               end else begin
                  outn = row_i;
               end
               frame_word[color][chans - 1 - outn] = gamma_word(pix);
            end
         end
         CMD_READ: begin
            if (int'(bidx) >= 24 * live_chips() || color > PLANE_BLUE) begin
               r.err = 1'b1;
            end else begin
               k  = int'(bidx) / 3;
               w0 = frame_word[color][2 * k];
               w1 = frame_word[color][2 * k + 1];
               case (2'(int'(bidx) % 3))
                  BYTE_HI:  r.data = w0[11:4];
                  BYTE_MID: r.data = {w0[3:0], w1[11:8]};
                  default:  r.data = w1[7:0];
               endcase
            end
         end
         CMD_CLEAR: begin
            clear_frame();
         end
         default: begin
         end
      endcase
      due_rsp_q.push_back(r);
   endtask

   task automatic send_op(input logic [1:0] cmd, input logic [5:0] row,
                          input logic [1:0] color, input logic [7:0] pix,
                          input logic [6:0] bidx);
      int gap;
      gap = tx_burst ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_led_row     <= row;
      req_color       <= color;
      req_pixel_value <= pix;
      req_byte_index  <= bidx;
      do @(posedge clock); while (!req_ready);
      update_frame(cmd, row, color, pix, bidx);
   endtask

   task automatic send_random_op();
      int         pick;
      int         chans;
      logic [7:0] pix;
      pick  = $urandom_range(0, 99);
      chans = 16 * live_chips();
      pix   = ($urandom_range(0, 9) == 0) ? (($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00)
                                           : 8'($urandom_range(0, 255));
      if (pick < 45) begin
         send_op(CMD_WRITE, 6'($urandom_range(0, chans - 1)), 2'($urandom_range(0, 2)),
                 pix, 7'($urandom_range(0, 127)));
      end else if (pick < 80) begin
         send_op(CMD_READ, 6'($urandom_range(0, 63)), 2'($urandom_range(0, 2)), pix,
                 7'($urandom_range(0, 24 * live_chips() - 1)));
      end else if (pick < 82) begin
         send_op(CMD_CLEAR, 6'($urandom_range(0, 63)), 2'($urandom_range(0, 3)), pix,
                 7'($urandom_range(0, 127)));
      end else begin
         send_op(2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
                 2'($urandom_range(0, 3)), pix, 7'($urandom_range(0, 127)));
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (due_rsp_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_config(input logic [2:0] chips, input logic [3:0] bits,
                             input logic bb);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= CSR_CHIP_COUNT;
      csr_wdata <= {1'($urandom_range(0, 1)), chips};
      @(posedge clock);
      csr_index <= CSR_PWM_BITS;
      csr_wdata <= bits;
      @(posedge clock);
      csr_index <= CSR_BREADBOARD;
      csr_wdata <= {3'($urandom_range(0, 7)), bb};
      @(posedge clock);
      // spare index must be ignored
      csr_index <= CSR_SPARE;
      csr_wdata <= 4'($urandom_range(0, 15));
      @(posedge clock);
      csr_we    <= 1'b0;
      cfg_chips = chips;
      cfg_bits  = bits;
      cfg_bb    = bb;
      @(posedge clock);
   endtask

   task automatic test_directed();
      send_op(CMD_WRITE, 6'd0,  PLANE_RED,   8'd255, 7'd0);
      send_op(CMD_WRITE, 6'd15, PLANE_RED,   8'd1,   7'd127);
      send_op(CMD_WRITE, 6'd1,  PLANE_RED,   8'd128, 7'd0);
      send_op(CMD_WRITE, 6'd16, PLANE_GREEN, 8'd200, 7'd0);
      send_op(CMD_WRITE, 6'd63, PLANE_BLUE,  8'd255, 7'd127);
      send_op(CMD_WRITE, 6'd5,  PLANE_NONE,  8'd100, 7'd0);
      send_op(CMD_WRITE, 6'd7,  PLANE_GREEN, 8'd0,   7'd0);
      send_op(CMD_WRITE, 6'd8,  PLANE_BLUE,  8'd77,  7'd0);
      send_op(CMD_READ,  6'd0,  PLANE_RED,   8'd0,   7'd0);
      send_op(CMD_READ,  6'd0,  PLANE_RED,   8'd0,   7'd1);
      send_op(CMD_READ,  6'd0,  PLANE_RED,   8'd0,   7'd2);
      send_op(CMD_READ,  6'd0,  PLANE_RED,   8'd0,   7'd21);
      send_op(CMD_READ,  6'd0,  PLANE_RED,   8'd0,   7'd22);
      send_op(CMD_READ,  6'd0,  PLANE_RED,   8'd0,   7'd23);
      send_op(CMD_READ,  6'd0,  PLANE_BLUE,  8'd0,   7'd10);
      send_op(CMD_READ,  6'd0,  PLANE_RED,   8'd0,   7'd24);
      send_op(CMD_READ,  6'd63, PLANE_BLUE,  8'd255, 7'd127);
      send_op(CMD_READ,  6'd0,  PLANE_NONE,  8'd0,   7'd0);
      send_op(CMD_UNUSED, 6'd63, PLANE_NONE, 8'd255, 7'd127);
      send_op(CMD_CLEAR, 6'd0,  PLANE_RED,   8'd0,   7'd0);
      send_op(CMD_READ,  6'd0,  PLANE_RED,   8'd0,   7'd23);
      send_op(CMD_READ,  6'd0,  PLANE_BLUE,  8'd0,   7'd10);
      send_op(CMD_WRITE, 6'd3,  PLANE_BLUE,  8'd77,  7'd0);
      send_op(CMD_READ,  6'd0,  PLANE_BLUE,  8'd0,   7'd18);
      send_op(CMD_READ,  6'd0,  PLANE_BLUE,  8'd0,   7'd19);
   endtask

   // mode 0: random idling both sides, 1: no idling, 2: sender never idles
   task automatic test_random_phase(input logic [2:0] chips, input logic [3:0] bits,
                                    input logic bb, input int count, input int mode);
      set_config(chips, bits, bb);
      tx_burst = (mode != 0);
      rx_burst = (mode == 1);
      repeat (count) send_random_op();
      tx_burst = 1'b0;
      rx_burst = 1'b0;
   endtask

   task automatic test_config_sweep();
      test_random_phase(3'd1, 4'd12, 1'b0, 140, 0);
      test_random_phase(3'd4, 4'd8,  1'b1, 140, 1);
      test_random_phase(3'd0, 4'd15, 1'b0, 140, 0);
      test_random_phase(3'd7, 4'd0,  1'b1, 140, 2);
      test_random_phase(3'd2, 4'd10, 1'b0, 140, 0);
      test_random_phase(3'd3, 4'd9,  1'b1, 140, 1);
      test_random_phase(3'd4, 4'd12, 1'b0, 140, 0);
      test_random_phase(3'd4, 4'd11, 1'b1, 140, 2);
      test_random_phase(3'd5, 4'd7,  1'b0, 140, 0);
      test_random_phase(3'd1, 4'd8,  1'b1, 140, 1);
   endtask

   task automatic test_backpressure();
      set_config(3'd4, 4'd12, 1'b1);
      rx_hold_cycles = 150;
      tx_burst = 1'b1;
      repeat (40) send_random_op();
      tx_burst = 1'b0;
      wait_idle();
   endtask

   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         if (rx_hold_cycles > 0) begin
            stall = rx_hold_cycles;
            rx_hold_cycles = 0;
         end else begin
            stall = rx_burst ? 0 : $urandom_range(0, 19);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   always @(posedge clock) begin
      packed_rsp_type exp_rsp;
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (rsp_valid && rsp_ready) begin
            if (due_rsp_q.size() == 0) begin
               $display("%0t: unexpected transaction, read_data %0h row_error %0b",
                        $time, rsp_read_data, rsp_row_error);
               fail_count = fail_count + 1;
            end else begin
               exp_rsp = due_rsp_q.pop_front();
               if (rsp_read_data !== exp_rsp.data) begin
                  $display("%0t: read_data mismatch, expected %0h, got %0h",
                           $time, exp_rsp.data, rsp_read_data);
                  fail_count = fail_count + 1;
               end
               if (rsp_row_error !== exp_rsp.err) begin
                  $display("%0t: row_error mismatch, expected %0b, got %0b",
                           $time, exp_rsp.err, rsp_row_error);
                  fail_count = fail_count + 1;
               end
            end
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: timeout, %0d transactions outstanding", $time, due_rsp_q.size());
            $display("Some tests failed");
            $finish;
         end
      end
   end

   initial begin
      clear_frame();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_config_sweep();
      test_backpressure();
      wait_idle();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && due_rsp_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
